### src/ugpe_pkg.sv
package ugpe_pkg;

  localparam int UGPE_NODES  = 64;
  localparam int NODE_W      = 6;
  localparam int MASK_W      = 64;
  localparam int KIND_W      = 3;
  localparam int S_TDATA_W   = 208;
  localparam int M_TDATA_W   = 8;

  typedef enum logic [KIND_W-1:0] {
    K_CLEAR   = 3'd0,
    K_ADD     = 3'd1,
    K_REMOVE  = 3'd2,
    K_PATH    = 3'd3,
    K_NREACH  = 3'd4,
    K_SREACH  = 3'd5
  } kind_e;

endpackage

### src/ugpe_ram.sv
module ugpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### src/undirected_graph_path_engine.sv
// Channel   Dir  tdata (low bit up)                                 tuser         tlast
// s_axis    in   node_a[5:0] node_b[11:6] from_set[75:12]           kind[2:0]     -
//                to_set[139:76] except_set[203:140] zero[207:204]
// m_axis    out  path_node[5:0] zero[7:6]                           found[0]      last
//
// Edge edits read row a, write row a while reading row b, then write row b; clearing all
// edges sweeps the adjacency RAM. Reach queries expand one node at a time: pick the lowest
// pending node, then read its row. Path queries dequeue a node, read its row and enqueue
// each new neighbor, then emit the path node by node through predecessor RAM reads.
// After reset the adjacency RAM is zeroed by a clearing pass; s_axis_tready
// stays low meanwhile. One item is worked at a time; a stalled m_axis holds the engine.
module undirected_graph_path_engine
  import ugpe_pkg::*;
#(
  parameter int NODES = UGPE_NODES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // node_a, node_b, from_set, to_set, except_set
  input  logic [KIND_W-1:0]    s_axis_tuser,  // kind
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // path_node
  output logic                 m_axis_tuser,  // found
  output logic                 m_axis_tlast   // last result of the query
);

  localparam int AW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ERDA, S_EWRA, S_EWRB, S_PINIT, S_QRD, S_QWAIT,
    S_AWAIT, S_SCAN, S_POUT, S_PRD, S_RCHK, S_RWAIT, S_REPLY
  } state_e;

  // Lowest set bit of a mask.
  function automatic logic [NODE_W-1:0] lowest(input logic [MASK_W-1:0] v);
    logic [NODE_W-1:0] idx;
    idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (v[i]) idx = NODE_W'(i);
    end
    return idx;
  endfunction

  state_e              state_q;
  logic [AW-1:0]       cnt_q;
  logic [NODE_W-1:0]   a_q, b_q, cur_q, p_q;
  logic                set_q, found_q;
  logic [MASK_W-1:0]   except_q, goal_q, pending_q, visited_q, row_q;
  logic [CW-1:0]       head_q, tail_q;
  logic [NODE_W-1:0]   path_node_q;
  logic                m_valid_q, m_found_q, m_last_q;

  // Input fields
  logic [NODE_W-1:0] in_a, in_b;
  logic [MASK_W-1:0] in_from, in_to, in_except;
  assign in_a      = s_axis_tdata[5:0];
  assign in_b      = s_axis_tdata[11:6];
  assign in_from   = s_axis_tdata[75:12];
  assign in_to     = s_axis_tdata[139:76];
  assign in_except = s_axis_tdata[203:140];

  // RAM ports
  logic              adj_we, adj_re;
  logic [AW-1:0]     adj_waddr, adj_raddr;
  logic [NODES-1:0]  adj_wdata, adj_rdata;
  logic              q_we, q_re;
  logic [AW-1:0]     q_waddr, q_raddr;
  logic [NODE_W-1:0] q_wdata, q_rdata;
  logic              p_we, p_re;
  logic [AW-1:0]     p_waddr, p_raddr;
  logic [NODE_W-1:0] p_wdata, p_rdata;

  ugpe_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_adj_ram (
    .clk_i, .we_i(adj_we), .waddr_i(adj_waddr), .wdata_i(adj_wdata),
    .re_i(adj_re), .raddr_i(adj_raddr), .rdata_o(adj_rdata)
  );

  ugpe_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_queue_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .re_i(q_re), .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  ugpe_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_pred_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .re_i(p_re), .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  logic              in_accept, out_free, out_load;
  logic              a_ok, b_ok, cur_ok;
  logic [NODES-1:0]  bit_a, bit_b;
  logic [MASK_W-1:0] row_ext;
  logic [NODE_W-1:0] scan_idx, pend_idx;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  // Load a result register whenever an output state finds it free.
  assign out_load      = out_free && ((state_q == S_POUT) || (state_q == S_REPLY));

  assign a_ok   = {1'b0, in_a} < (NODE_W + 1)'(NODES);
  assign b_ok   = {1'b0, in_b} < (NODE_W + 1)'(NODES);
  assign cur_ok = {1'b0, cur_q} < (NODE_W + 1)'(NODES);
  assign bit_a  = {{(NODES - 1){1'b0}}, 1'b1} << a_q[AW-1:0];
  assign bit_b  = {{(NODES - 1){1'b0}}, 1'b1} << b_q[AW-1:0];
  // Rows of nodes beyond the graph read as empty.
  assign row_ext  = cur_ok ? MASK_W'(adj_rdata) : '0;
  assign scan_idx = lowest(row_q);
  assign pend_idx = lowest(pending_q);

  // RAM control
  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = a_q[AW-1:0];
    adj_wdata = '0;
    adj_re    = 1'b0;
    adj_raddr = a_q[AW-1:0];
    q_we      = 1'b0;
    q_waddr   = tail_q[AW-1:0];
    q_wdata   = scan_idx;
    q_re      = 1'b0;
    q_raddr   = head_q[AW-1:0];
    p_we      = 1'b0;
    p_waddr   = scan_idx[AW-1:0];
    p_wdata   = cur_q;
    p_re      = 1'b0;
    p_raddr   = p_q[AW-1:0];
    unique case (state_q)
      S_CLR: begin
        adj_we    = 1'b1;
        adj_waddr = cnt_q;
      end
      S_ERDA: adj_re = 1'b1;
      S_EWRA: begin
        adj_we    = 1'b1;
        adj_wdata = set_q ? (adj_rdata | bit_b) : (adj_rdata & ~bit_b);
        adj_re    = 1'b1;
        adj_raddr = b_q[AW-1:0];
      end
      S_EWRB: begin
        adj_we    = 1'b1;
        adj_waddr = b_q[AW-1:0];
        adj_wdata = set_q ? (adj_rdata | bit_a) : (adj_rdata & ~bit_a);
      end
      S_PINIT: begin
        q_we    = 1'b1;
        q_waddr = '0;
        q_wdata = b_q;
      end
      S_QRD: q_re = (head_q != tail_q);
      S_QWAIT: begin
        adj_re    = 1'b1;
        adj_raddr = q_rdata[AW-1:0];
      end
      S_SCAN: begin
        if (row_q[a_q]) begin
          p_we    = 1'b1;
          p_waddr = a_q[AW-1:0];
        end else if (row_q != '0) begin
          p_we = 1'b1;
          q_we = (tail_q < CW'(NODES));
        end
      end
      S_POUT: p_re = out_free && (p_q != b_q);
      S_RCHK: begin
        adj_re    = (pending_q != '0) && ((pending_q & goal_q) == '0);
        adj_raddr = pend_idx[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      pending_q <= '0;
      visited_q <= '0;
    end else begin
      // Load a new result, or drop the current one once the sink takes it.
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLR: begin
          cnt_q <= cnt_q + AW'(1);
          if (cnt_q == AW'(NODES - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_accept) begin
            a_q      <= in_a;
            b_q      <= in_b;
            except_q <= in_except;
            unique case (s_axis_tuser)
              K_CLEAR: begin
                cnt_q   <= '0;
                state_q <= S_CLR;
              end
              K_ADD: begin
                set_q <= 1'b1;
                if (a_ok && b_ok && (in_a != in_b)) state_q <= S_ERDA;
              end
              K_REMOVE: begin
                set_q <= 1'b0;
                if (a_ok && b_ok) state_q <= S_ERDA;
              end
              K_PATH: begin
                visited_q <= MASK_W'(1) << in_b;
                state_q   <= S_PINIT;
              end
              K_NREACH: begin
                if (in_except[in_b]) begin
                  found_q <= 1'b0;
                  state_q <= S_REPLY;
                end else begin
                  pending_q <= MASK_W'(1) << in_a;
                  goal_q    <= MASK_W'(1) << in_b;
                  visited_q <= '0;
                  state_q   <= S_RCHK;
                end
              end
              K_SREACH: begin
                pending_q <= in_from;
                goal_q    <= in_to;
                visited_q <= '0;
                state_q   <= S_RCHK;
              end
              default: ;
            endcase
          end
        end
        S_ERDA: state_q <= S_EWRA;
        S_EWRA: state_q <= S_EWRB;
        S_EWRB: state_q <= S_IDLE;
        S_PINIT: begin
          head_q  <= '0;
          tail_q  <= CW'(1);
          state_q <= S_QRD;
        end
        S_QRD: begin
          if (head_q == tail_q) begin
            found_q <= 1'b0;
            state_q <= S_REPLY;
          end else begin
            head_q  <= head_q + CW'(1);
            state_q <= S_QWAIT;
          end
        end
        S_QWAIT: begin
          cur_q   <= q_rdata;
          state_q <= S_AWAIT;
        end
        S_AWAIT: begin
          row_q     <= row_ext & ~visited_q;
          visited_q <= visited_q | row_ext;
          state_q   <= S_SCAN;
        end
        S_SCAN: begin
          if (row_q[a_q]) begin
            p_q     <= a_q;
            state_q <= S_POUT;
          end else if (row_q == '0) begin
            state_q <= S_QRD;
          end else begin
            if (tail_q < CW'(NODES)) tail_q <= tail_q + CW'(1);
            row_q[scan_idx] <= 1'b0;
          end
        end
        S_POUT: begin
          if (out_free) begin
            path_node_q <= p_q;
            m_found_q   <= 1'b1;
            m_last_q    <= (p_q == b_q);
            state_q     <= (p_q == b_q) ? S_IDLE : S_PRD;
          end
        end
        S_PRD: begin
          p_q     <= p_rdata;
          state_q <= S_POUT;
        end
        S_RCHK: begin
          if (pending_q == '0) begin
            found_q <= 1'b0;
            state_q <= S_REPLY;
          end else if ((pending_q & goal_q) != '0) begin
            found_q <= 1'b1;
            state_q <= S_REPLY;
          end else begin
            pending_q[pend_idx] <= 1'b0;
            visited_q[pend_idx] <= 1'b1;
            cur_q               <= pend_idx;
            state_q             <= S_RWAIT;
          end
        end
        S_RWAIT: begin
          pending_q <= pending_q | (row_ext & ~visited_q & ~except_q);
          state_q   <= S_RCHK;
        end
        S_REPLY: begin
          if (out_free) begin
            path_node_q <= '0;
            m_found_q   <= found_q;
            m_last_q    <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(path_node_q);
  assign m_axis_tuser  = m_found_q;
  assign m_axis_tlast  = m_last_q;

endmodule

### src/ugpe_checker.sv
module ugpe_checker
  import ugpe_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic [KIND_W-1:0]    s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tuser,
  input logic                 m_axis_tlast
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // A not-found result is a single last transaction with node zero.
  a_nf_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("not-found result malformed");

  // The engine stays busy while a path is still being emitted.
  a_busy_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken during path output");

  // Node numbers fit the node field.
  a_node_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:NODE_W] == '0))
    else $error("pad bits set");

endmodule

bind undirected_graph_path_engine ugpe_checker u_ugpe_checker (.*);
